// ===== src/lgs_pkg.sv =====
// ----------------------------------------------------------------------------
// lgs_pkg: shared types and constants of the life grid step unit
// Operation codes, register indexes, rule constants and the cell rule.
// ----------------------------------------------------------------------------
`default_nettype none

package lgs_pkg;

    // operation codes carried by a request
    typedef enum logic [1:0] {
        FUNC_WRITE   = 2'd0,
        FUNC_ADVANCE = 2'd1,
        FUNC_READ    = 2'd2
    } t_func;

    // configuration register indexes
    localparam logic CFG_ROWS = 1'b0;
    localparam logic CFG_COLS = 1'b1;

    // size registers after reset
    localparam logic [6:0] ACT_RESET = 7'd64;

    // rule b3/s23
    localparam logic [3:0] BIRTH_COUNT  = 4'd3;
    localparam logic [3:0] SURVIVE_LOW  = 4'd2;
    localparam logic [3:0] SURVIVE_HIGH = 4'd3;

    // next value of one cell from its state and live neighbour count
    function automatic logic next_cell(input logic alive, input logic [3:0] count);
        logic res;
        if (alive) begin
            res = (count >= SURVIVE_LOW) && (count <= SURVIVE_HIGH);
        end else begin
            res = (count == BIRTH_COUNT);
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// ===== src/lgs_req_if.sv =====
// ----------------------------------------------------------------------------
// lgs_req_if: request channel
// Valid/ready channel carrying one cell operation.
// ----------------------------------------------------------------------------
`default_nettype none

interface lgs_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] func;
    logic [5:0] row;
    logic [5:0] col;
    logic       alive_in;

    modport source (output valid, output func, output row, output col,
                    output alive_in, input ready);
    modport sink   (input valid, input func, input row, input col,
                    input alive_in, output ready);
endinterface

`default_nettype wire

// ===== src/lgs_rsp_if.sv =====
// ----------------------------------------------------------------------------
// lgs_rsp_if: result channel
// Valid/ready channel carrying one result per request.
// ----------------------------------------------------------------------------
`default_nettype none

interface lgs_rsp_if;
    logic       valid;
    logic       ready;
    logic       alive_out;
    logic [1:0] op_done;

    modport source (output valid, output alive_out, output op_done, input ready);
    modport sink   (input valid, input alive_out, input op_done, output ready);
endinterface

`default_nettype wire

// ===== src/life_grid_generation_step_unit.sv =====
// ----------------------------------------------------------------------------
// life_grid_generation_step_unit: game of life grid, rule b3/s23
// The grid sits in a row-wide synchronous memory of MAX_ROWS words of
// MAX_COLS bits. After reset a clearing pass writes every row dead, one row
// a cycle, so no request is taken until the pass ends; size register writes
// are taken during it. A cell write or read goes from request to result by
// a row read, a modify and write back or bit select, and a result load. An
// advance walks the active rows once, a memory read and a write back of the
// new row for each row, through the old-row registers r_above and r_mid and
// the read data register. One request is in work at a time; a new one is
// taken while the previous result still waits in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module life_grid_generation_step_unit
    import lgs_pkg::*;
#(
    parameter int MAX_ROWS = 64,
    parameter int MAX_COLS = 64
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_cfg_we,
    input  wire         i_cfg_idx,
    input  wire  [6:0]  i_cfg_data,
    lgs_req_if.sink     i_req,
    lgs_rsp_if.source   o_rsp
);

    localparam int ROW_AW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int COL_AW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int ROW_CW = ($clog2(MAX_ROWS + 1) > 7) ? $clog2(MAX_ROWS + 1) : 7;
    localparam int COL_CW = ($clog2(MAX_COLS + 1) > 7) ? $clog2(MAX_COLS + 1) : 7;

    typedef enum logic [5:0] {
        S_CLEAR  = 6'b000001,
        S_IDLE   = 6'b000010,
        S_CELL   = 6'b000100,
        S_ADV_RD = 6'b001000,
        S_ADV_WB = 6'b010000,
        S_FIN    = 6'b100000
    } t_state;

    // grid memory, one word per row
    logic [MAX_COLS-1:0] mem [MAX_ROWS];

    t_state              r_state, n_state;
    logic [ROW_CW-1:0]   r_k, n_k;
    logic [MAX_COLS-1:0] r_above, n_above;
    logic [MAX_COLS-1:0] r_mid, n_mid;
    logic [1:0]          r_func, n_func;
    logic [ROW_AW-1:0]   r_row_addr, n_row_addr;
    logic [COL_AW-1:0]   r_col_idx, n_col_idx;
    logic                r_alive, n_alive;
    logic                r_inside, n_inside;
    logic                r_res_alive, n_res_alive;
    logic                r_out_valid, n_out_valid;
    logic                r_out_alive, n_out_alive;
    logic [1:0]          r_out_op, n_out_op;
    logic [6:0]          r_act_rows, r_act_cols;
    logic [MAX_COLS-1:0] r_rd_data;

    logic [ROW_CW-1:0]   eff_rows;
    logic [COL_CW-1:0]   eff_cols;
    logic [ROW_CW-1:0]   req_row_ext, k_m1;
    logic [COL_CW-1:0]   req_col_ext;
    logic                req_accept;

    logic                mem_re, mem_we;
    logic [ROW_AW-1:0]   mem_raddr, mem_waddr;
    logic [MAX_COLS-1:0] mem_wdata;

    logic [MAX_COLS-1:0] col_mask, below_row, new_row, cell_row;
    logic [MAX_COLS+1:0] pad_above, pad_mid, pad_below;

    // active area clipped to the grid
    assign eff_rows = (ROW_CW'(r_act_rows) > ROW_CW'(MAX_ROWS)) ?
                      ROW_CW'(MAX_ROWS) : ROW_CW'(r_act_rows);
    assign eff_cols = (COL_CW'(r_act_cols) > COL_CW'(MAX_COLS)) ?
                      COL_CW'(MAX_COLS) : COL_CW'(r_act_cols);

    assign req_row_ext = ROW_CW'(i_req.row);
    assign req_col_ext = COL_CW'(i_req.col);
    assign k_m1        = r_k - ROW_CW'(1);

    assign i_req.ready     = (r_state == S_IDLE);
    assign req_accept      = i_req.valid && i_req.ready;
    assign o_rsp.valid     = r_out_valid;
    assign o_rsp.alive_out = r_out_alive;
    assign o_rsp.op_done   = r_out_op;

    // next generation of the row held in r_mid
    always_comb begin
        logic [3:0] cnt;
        below_row = (r_k < eff_rows) ? r_rd_data : '0;
        for (int c = 0; c < MAX_COLS; c++) begin
            col_mask[c] = (COL_CW'(c) < eff_cols);
        end
        pad_above = {1'b0, r_above & col_mask, 1'b0};
        pad_mid   = {1'b0, r_mid & col_mask, 1'b0};
        pad_below = {1'b0, below_row & col_mask, 1'b0};
        for (int c = 0; c < MAX_COLS; c++) begin
            cnt = {3'b0, pad_above[c]} + {3'b0, pad_above[c+1]} + {3'b0, pad_above[c+2]}
                + {3'b0, pad_mid[c]}                            + {3'b0, pad_mid[c+2]}
                + {3'b0, pad_below[c]} + {3'b0, pad_below[c+1]} + {3'b0, pad_below[c+2]};
            new_row[c] = col_mask[c] ? next_cell(r_mid[c], cnt) : r_mid[c];
        end
    end

    // cell write merged into the fetched row
    always_comb begin
        cell_row            = r_rd_data;
        cell_row[r_col_idx] = r_alive;
    end

    // control and memory access
    always_comb begin
        n_state     = r_state;
        n_k         = r_k;
        n_above     = r_above;
        n_mid       = r_mid;
        n_func      = r_func;
        n_row_addr  = r_row_addr;
        n_col_idx   = r_col_idx;
        n_alive     = r_alive;
        n_inside    = r_inside;
        n_res_alive = r_res_alive;
        n_out_valid = r_out_valid;
        n_out_alive = r_out_alive;
        n_out_op    = r_out_op;
        mem_re      = 1'b0;
        mem_raddr   = r_row_addr;
        mem_we      = 1'b0;
        mem_waddr   = r_row_addr;
        mem_wdata   = cell_row;

        if (o_rsp.valid && o_rsp.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_k[ROW_AW-1:0];
                mem_wdata = '0;
                if (r_k == ROW_CW'(MAX_ROWS - 1)) begin
                    n_k     = '0;
                    n_state = S_IDLE;
                end else begin
                    n_k = r_k + ROW_CW'(1);
                end
            end
            S_IDLE: begin
                if (req_accept) begin
                    n_func      = i_req.func;
                    n_row_addr  = req_row_ext[ROW_AW-1:0];
                    n_col_idx   = req_col_ext[COL_AW-1:0];
                    n_alive     = i_req.alive_in;
                    n_inside    = (req_row_ext < eff_rows) && (req_col_ext < eff_cols);
                    n_res_alive = 1'b0;
                    n_k         = '0;
                    n_above     = '0;
                    n_mid       = '0;
                    if (i_req.func == FUNC_WRITE || i_req.func == FUNC_READ) begin
                        mem_re    = 1'b1;
                        mem_raddr = req_row_ext[ROW_AW-1:0];
                        n_state   = S_CELL;
                    end else if (i_req.func == FUNC_ADVANCE) begin
                        n_state = S_ADV_RD;
                    end else begin
                        n_state = S_FIN;
                    end
                end
            end
            S_CELL: begin
                // row data is back: write it modified or pick the bit
                if (r_func == FUNC_WRITE) begin
                    mem_we = r_inside;
                end else begin
                    n_res_alive = r_inside && r_rd_data[r_col_idx];
                end
                n_state = S_FIN;
            end
            S_ADV_RD: begin
                mem_re    = (r_k < eff_rows);
                mem_raddr = r_k[ROW_AW-1:0];
                n_state   = S_ADV_WB;
            end
            S_ADV_WB: begin
                // rows already rewritten stay in the old-row registers
                mem_we    = (r_k != '0);
                mem_waddr = k_m1[ROW_AW-1:0];
                mem_wdata = new_row;
                n_above   = r_mid;
                n_mid     = below_row;
                if (r_k == eff_rows) begin
                    n_state = S_FIN;
                end else begin
                    n_k     = r_k + ROW_CW'(1);
                    n_state = S_ADV_RD;
                end
            end
            S_FIN: begin
                if (!r_out_valid || o_rsp.ready) begin
                    n_out_valid = 1'b1;
                    n_out_alive = r_res_alive;
                    n_out_op    = r_func;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // grid memory, read data registered
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rd_data <= mem[mem_raddr];
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_k         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_k         <= n_k;
            r_out_valid <= n_out_valid;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        r_above     <= n_above;
        r_mid       <= n_mid;
        r_func      <= n_func;
        r_row_addr  <= n_row_addr;
        r_col_idx   <= n_col_idx;
        r_alive     <= n_alive;
        r_inside    <= n_inside;
        r_res_alive <= n_res_alive;
        r_out_alive <= n_out_alive;
        r_out_op    <= n_out_op;
    end

    // size registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act_rows <= ACT_RESET;
            r_act_cols <= ACT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_ROWS: r_act_rows <= i_cfg_data;
                CFG_COLS: r_act_cols <= i_cfg_data;
                default:  r_act_rows <= r_act_rows;
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== src/lgs_checker.sv =====
// ----------------------------------------------------------------------------
// lgs_checker: port checks of the life grid step unit
// Tracks outstanding requests and checks results against them.
// ----------------------------------------------------------------------------
`default_nettype none

module lgs_checker
    import lgs_pkg::*;
(
    input wire       i_clk,
    input wire       i_rst_n,
    input wire       i_req_valid,
    input wire       i_req_ready,
    input wire       i_rsp_valid,
    input wire       i_rsp_ready,
    input wire       i_alive_out,
    input wire [1:0] i_op_done
);

    logic [1:0] r_pending;

    // requests taken but not yet answered
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
        end else begin
            r_pending <= r_pending + 2'((i_req_valid && i_req_ready) ? 1 : 0)
                                   - 2'((i_rsp_valid && i_rsp_ready) ? 1 : 0);
        end
    end

    // no result straight after reset
    a_reset_quiet: assert property (@(posedge i_clk) !i_rst_n |=> !i_rsp_valid)
        else $error("result valid after reset");

    // a result needs a request behind it
    a_no_invented: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |-> (r_pending != 2'd0))
        else $error("result without a pending request");

    // at most one in work and one waiting
    a_pending_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pending != 2'd3)
        else $error("too many requests in flight");

    // only a read returns a live cell
    a_alive_read_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && i_op_done != FUNC_READ) |-> !i_alive_out)
        else $error("live cell on a non-read result");

    // a stalled result holds
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && !i_rsp_ready) |=>
            (i_rsp_valid && $stable(i_alive_out) && $stable(i_op_done)))
        else $error("stalled result changed");

endmodule

bind life_grid_generation_step_unit lgs_checker u_lgs_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_req_valid (i_req.valid),
    .i_req_ready (i_req.ready),
    .i_rsp_valid (o_rsp.valid),
    .i_rsp_ready (o_rsp.ready),
    .i_alive_out (o_rsp.alive_out),
    .i_op_done   (o_rsp.op_done)
);

`default_nettype wire

// ===== sim/lgs_grid_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lgs_grid_checker: result checker of the life grid step unit
// Watches the size register port and both channels. It keeps its own copy of
// the grid and the sizes, works out the result of every accepted request and
// compares the results that leave the block with these, oldest first.
// ----------------------------------------------------------------------------
module lgs_grid_checker
    import lgs_pkg::*;
(
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_cfg_we,
    input  wire        i_cfg_idx,
    input  wire  [6:0] i_cfg_data,
    lgs_req_if         i_req,
    lgs_rsp_if         i_rsp,
    output int         o_fail_count,
    output int         o_outstanding
);

    localparam int GRID_ROWS = 64;
    localparam int GRID_COLS = 64;

    typedef struct packed {
        logic       alive_out;
        logic [1:0] op_done;
    } t_cell_result;

    // grid copy, one word per row, bit index is the column
    logic [GRID_COLS-1:0] life_grid [GRID_ROWS];
    logic [GRID_COLS-1:0] prev_grid [GRID_ROWS];
    logic [6:0]           rows_reg;
    logic [6:0]           cols_reg;
    t_cell_result         expected_results [$];
    int                   mismatch_count = 0;

    // size in use: register value capped at the grid size
    function automatic int used_size(input logic [6:0] reg_val, input int limit);
        return (int'(reg_val) < limit) ? int'(reg_val) : limit;
    endfunction

    // live cells around one cell of the old generation, outside counts dead
    function automatic int live_neighbours(input int r, input int c,
                                           input int nr, input int nc);
        int count;
        int dr;
        int dc;
        count = 0;
        for (dr = -1; dr <= 1; dr++) begin
            for (dc = -1; dc <= 1; dc++) begin
                if ((dr != 0 || dc != 0) && r + dr >= 0 && c + dc >= 0 &&
                    r + dr < nr && c + dc < nc) begin
                    count += int'(prev_grid[r + dr][c + dc]);
                end
            end
        end
        return count;
    endfunction

    // one generation of the active area, cells outside keep their values
    function automatic void advance_generation();
        int nr;
        int nc;
        int n;
        nr = used_size(rows_reg, GRID_ROWS);
        nc = used_size(cols_reg, GRID_COLS);
        for (int r = 0; r < GRID_ROWS; r++) begin
            prev_grid[r] = life_grid[r];
        end
        for (int r = 0; r < nr; r++) begin
            for (int c = 0; c < nc; c++) begin
                n = live_neighbours(r, c, nr, nc);
                if (prev_grid[r][c]) begin
                    life_grid[r][c] = (n >= SURVIVE_LOW) && (n <= SURVIVE_HIGH);
                end else begin
                    life_grid[r][c] = (n == BIRTH_COUNT);
                end
            end
        end
    endfunction

    // apply one request to the grid copy and give its result
    function automatic t_cell_result predict_request(input logic [1:0] func,
                                                     input logic [5:0] row,
                                                     input logic [5:0] col,
                                                     input logic alive_in);
        t_cell_result res;
        logic         in_area;
        in_area = (int'(row) < used_size(rows_reg, GRID_ROWS)) &&
                  (int'(col) < used_size(cols_reg, GRID_COLS));
        res.alive_out = 1'b0;
        res.op_done   = func;
        case (func)
            FUNC_WRITE: begin
                if (in_area) life_grid[row][col] = alive_in;
            end
            FUNC_ADVANCE: begin
                advance_generation();
            end
            FUNC_READ: begin
                if (in_area) res.alive_out = life_grid[row][col];
            end
            default: begin
                // spare code: no change, echo only
            end
        endcase
        return res;
    endfunction

    always @(posedge i_clk) begin : check_proc
        t_cell_result want;
        if (!i_rst_n) begin
            for (int r = 0; r < GRID_ROWS; r++) begin
                life_grid[r] = '0;
                prev_grid[r] = '0;
            end
            rows_reg = ACT_RESET;
            cols_reg = ACT_RESET;
            expected_results.delete();
        end else begin
            // results leaving the block, compared first: none can belong to
            // a request taken at this same edge
            if (i_rsp.valid && i_rsp.ready) begin
                if (expected_results.size() == 0) begin
                    $error("unexpected result: op_done %0d alive_out %0b",
                           i_rsp.op_done, i_rsp.alive_out);
                    mismatch_count++;
                end else begin
                    want = expected_results.pop_front();
                    if (i_rsp.op_done !== want.op_done) begin
                        $error("op_done mismatch: expected %0d, actual %0d",
                               want.op_done, i_rsp.op_done);
                        mismatch_count++;
                    end
                    if (i_rsp.alive_out !== want.alive_out) begin
                        $error("alive_out mismatch: expected %0b, actual %0b",
                               want.alive_out, i_rsp.alive_out);
                        mismatch_count++;
                    end
                end
            end
            // accepted request
            if (i_req.valid && i_req.ready) begin
                want = predict_request(i_req.func, i_req.row, i_req.col, i_req.alive_in);
                expected_results.push_back(want);
            end
            // size register write takes effect after this edge
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_ROWS) begin
                    rows_reg = i_cfg_data;
                end else begin
                    cols_reg = i_cfg_data;
                end
            end
        end
        // results still owed count as failures if the run ends here
        o_outstanding = expected_results.size();
        o_fail_count  = mismatch_count + o_outstanding;
    end

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: testbench of the life grid step unit
// Drives cell writes, reads and generation steps under changing grid sizes,
// with random idle bursts on both channels, and lets the checker compare
// every result. Directed corner cases first, then random pattern and noise phases.
// ----------------------------------------------------------------------------
module tb_top;
    import lgs_pkg::*;

    localparam logic [1:0] FUNC_SPARE     = 2'd3;
    localparam int         DIRECTED_ITEMS = 22;
    localparam int         RANDOM_ITEMS   = 110;
    localparam int         QUIET_ITEMS    = 30;
    localparam int         TAIL_CYCLES    = 300;
    localparam int         CYCLE_LIMIT    = 400000;

    logic       clk;
    logic       rst_n;
    logic       cfg_we;
    logic       cfg_idx;
    logic [6:0] cfg_data;
    int         fail_count;
    int         outstanding;
    int         item_count = 0;
    int         cycle_count = 0;
    int         gap_pct = 20;
    int         stall_pct = 20;
    int         stall_left = 0;
    logic       quiet = 1'b0;

    lgs_req_if req_ch ();
    lgs_rsp_if rsp_ch ();

    life_grid_generation_step_unit #(
        .MAX_ROWS (64),
        .MAX_COLS (64)
    ) i_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_req      (req_ch),
        .o_rsp      (rsp_ch)
    );

    lgs_grid_checker u_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_idx     (cfg_idx),
        .i_cfg_data    (cfg_data),
        .i_req         (req_ch),
        .i_rsp         (rsp_ch),
        .o_fail_count  (fail_count),
        .o_outstanding (outstanding)
    );

    // clock
    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // run limit
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // result side: ready with random stall bursts
    always @(negedge clk) begin
        if (stall_left > 0) begin
            rsp_ch.ready = 1'b0;
            stall_left--;
        end else if (!quiet && $urandom_range(0, 99) < stall_pct) begin
            rsp_ch.ready = 1'b0;
            stall_left = $urandom_range(1, 17) - 1;
        end else begin
            rsp_ch.ready = 1'b1;
        end
    end

    // one request, with an optional idle burst ahead of it; returns at a
    // falling edge with valid still high
    task automatic send_request(input logic [1:0] func, input int row, input int col,
                                input logic alive_in);
        if (!quiet && $urandom_range(0, 99) < gap_pct) begin
            req_ch.valid = 1'b0;
            repeat ($urandom_range(1, 17)) @(negedge clk);
        end
        req_ch.valid    = 1'b1;
        req_ch.func     = func;
        req_ch.row      = 6'(row);
        req_ch.col      = 6'(col);
        req_ch.alive_in = alive_in;
        @(posedge clk);
        while (!req_ch.ready) @(posedge clk);
        @(negedge clk);
        item_count++;
    endtask

    // advance, with fields that carry no meaning set at random
    task automatic send_advance();
        send_request(FUNC_ADVANCE, $urandom_range(0, 63), $urandom_range(0, 63),
                     1'($urandom_range(0, 1)));
    endtask

    // any request at all, spare code included
    task automatic send_noise();
        send_request(2'($urandom_range(0, 3)), $urandom_range(0, 63),
                     $urandom_range(0, 63), 1'($urandom_range(0, 1)));
    endtask

    // stop sending and wait until every result is back
    task automatic wait_for_results();
        req_ch.valid = 1'b0;
        while (outstanding != 0) @(negedge clk);
    endtask

    task automatic write_reg(input logic idx, input int value);
        cfg_we   = 1'b1;
        cfg_idx  = idx;
        cfg_data = 7'(value);
        @(negedge clk);
        cfg_we   = 1'b0;
    endtask

    // grid size register value, extremes favoured
    function automatic int pick_size();
        case ($urandom_range(0, 9))
            0: return 0;
            1: return 1;
            2: return 64;
            3: return $urandom_range(65, 126);
            4: return 127;
            default: return $urandom_range(3, 12);
        endcase
    endfunction

    function automatic int clip_index(input int v);
        return (v < 0) ? 0 : ((v > 63) ? 63 : v);
    endfunction

    initial begin : stimulus
        int rows;
        int cols;
        int eff_r;
        int eff_c;
        int h;
        int w;
        int r0;
        int c0;

        rst_n           = 1'b0;
        cfg_we          = 1'b0;
        cfg_idx         = CFG_ROWS;
        cfg_data        = '0;
        req_ch.valid    = 1'b0;
        req_ch.func     = FUNC_WRITE;
        req_ch.row      = '0;
        req_ch.col      = '0;
        req_ch.alive_in = 1'b0;
        rsp_ch.ready    = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // corners of the full grid, read ignores alive_in
        send_request(FUNC_READ, 0, 0, 1'b1);
        send_request(FUNC_WRITE, 63, 63, 1'b1);
        send_request(FUNC_READ, 63, 63, 1'b0);
        send_request(FUNC_WRITE, 0, 63, 1'b1);
        send_request(FUNC_WRITE, 63, 0, 1'b1);
        send_request(FUNC_READ, 63, 0, 1'b1);
        // spare code changes nothing
        send_request(FUNC_SPARE, 63, 63, 1'b1);
        // lone cells die
        send_request(FUNC_ADVANCE, 63, 63, 1'b1);
        send_request(FUNC_READ, 63, 63, 1'b0);
        // blinker on the top edge, the row above counts dead
        send_request(FUNC_WRITE, 0, 0, 1'b1);
        send_request(FUNC_WRITE, 0, 1, 1'b1);
        send_request(FUNC_WRITE, 0, 2, 1'b1);
        send_advance();
        send_request(FUNC_READ, 1, 1, 1'b0);
        send_request(FUNC_READ, 0, 0, 1'b0);

        // no active rows: writes ignored, reads dead, advance does nothing
        wait_for_results();
        write_reg(CFG_ROWS, 0);
        send_request(FUNC_WRITE, 0, 1, 1'b0);
        send_request(FUNC_READ, 0, 1, 1'b0);
        send_advance();

        // rows above the grid size, two columns: kept cells show again
        wait_for_results();
        write_reg(CFG_ROWS, 127);
        write_reg(CFG_COLS, 2);
        send_request(FUNC_READ, 0, 1, 1'b0);
        send_request(FUNC_READ, 1, 1, 1'b0);
        send_request(FUNC_READ, 0, 2, 1'b0);
        send_advance();

        // random phases, each under a fresh grid size
        while (item_count < DIRECTED_ITEMS + RANDOM_ITEMS) begin
            wait_for_results();
            rows = pick_size();
            cols = pick_size();
            write_reg(CFG_ROWS, rows);
            write_reg(CFG_COLS, cols);
            if (item_count >= DIRECTED_ITEMS + RANDOM_ITEMS - QUIET_ITEMS) begin
                quiet = 1'b1;
            end
            if ($urandom_range(0, 3) == 0) begin
                gap_pct   = 0;
                stall_pct = 0;
            end else begin
                gap_pct   = $urandom_range(10, 40);
                stall_pct = $urandom_range(10, 40);
            end
            eff_r = (rows < 64) ? rows : 64;
            eff_c = (cols < 64) ? cols : 64;

            if (eff_r == 0 || eff_c == 0 || $urandom_range(0, 5) == 0) begin
                // noise phase
                repeat (8) send_noise();
            end else begin
                // pattern phase: seed a small window, step, read around it
                h  = (eff_r < 6) ? eff_r : 6;
                w  = (eff_c < 6) ? eff_c : 6;
                r0 = ($urandom_range(0, 2) == 0) ? eff_r - h : $urandom_range(0, eff_r - h);
                c0 = ($urandom_range(0, 2) == 0) ? eff_c - w : $urandom_range(0, eff_c - w);
                repeat ($urandom_range(3, 10)) begin
                    send_request(FUNC_WRITE, r0 + $urandom_range(0, h - 1),
                                 c0 + $urandom_range(0, w - 1), $urandom_range(0, 4) != 0);
                end
                repeat ($urandom_range(1, 3)) begin
                    send_advance();
                    repeat ($urandom_range(2, 5)) begin
                        send_request(FUNC_READ,
                                     clip_index(int'($urandom_range(0, h + 1)) + r0 - 1),
                                     clip_index(int'($urandom_range(0, w + 1)) + c0 - 1),
                                     1'($urandom_range(0, 1)));
                    end
                    if ($urandom_range(0, 4) == 0) send_noise();
                end
            end
        end

        wait_for_results();
        repeat (TAIL_CYCLES) @(negedge clk);
        if (fail_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
src/lgs_pkg.sv
src/lgs_req_if.sv
src/lgs_rsp_if.sv
src/life_grid_generation_step_unit.sv
src/lgs_checker.sv
sim/lgs_grid_checker.sv
sim/tb_top.sv
